// ===== rtl/swtrm_pkg.sv =====
// Shared widths, reset values, register indexes and control types of the rate meter.
package swtrm_pkg;

	// Default depth of the window store
	localparam int unsigned FIFO_DEPTH_DEF = 1024;

	// Field widths
	localparam int unsigned TIME_W    = 31;
	localparam int unsigned BYTES_W   = 16;
	localparam int unsigned BITS_W    = BYTES_W + 3;
	localparam int unsigned WINDOW_W  = 31;
	localparam int unsigned SCALE_W   = 20;
	localparam int unsigned RATE_W    = 40;
	localparam int unsigned LOST_W    = 11;
	localparam int unsigned NUM_RATES = 5;

	// Stream and configuration port widths
	localparam int unsigned IN_DATA_W  = 48;
	localparam int unsigned IN_USER_W  = 3;
	localparam int unsigned OUT_DATA_W = 216;
	localparam int unsigned OUT_PAD_W  = OUT_DATA_W - NUM_RATES * RATE_W - LOST_W;
	localparam int unsigned OUT_USER_W = 1;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 31;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd1;

	// Reset values and limits
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 31'd200000;
	localparam logic [SCALE_W-1:0]  SCALE_RESET  = 20'd5;
	localparam logic [RATE_W-1:0]   RATE_MAX     = 40'hFF_FFFF_FFFF;
	localparam logic [LOST_W-1:0]   LOST_MAX     = 11'd2047;

	// Rate classes, index into the sum bank
	localparam int unsigned RC_MEDIA = 0;
	localparam int unsigned RC_RTX   = 1;
	localparam int unsigned RC_PROBE = 2;
	localparam int unsigned RC_TOTAL = 3;
	localparam int unsigned RC_RECV  = 4;

	// One stored packet record
	typedef struct packed {
		logic [TIME_W-1:0]  send_time;
		logic [BYTES_W-1:0] packet_bytes;
		logic               rtx;
		logic               probe;
		logic               lost;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic load_item;
		logic pop;
		logic push;
		logic flag_ovf;
		logic mul;
		logic load_out;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic nonempty;
		logic full;
		logic stale;
	} dp_status_t;

endpackage

// ===== rtl/swtrm_ctrl.sv =====
// Sequencer of the rate meter: window test, pop loop, push, scaling and result hand-off.
module swtrm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  swtrm_pkg::dp_status_t status,
	output swtrm_pkg::dp_cmd_t    cmd
);
	import swtrm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TEST,
		S_WAIT,
		S_PUSH,
		S_MUL,
		S_OUT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_TEST;
				end
			end
			S_TEST: begin
				priority if (status.nonempty && status.stale) begin
					cmd.pop = 1'b1;
					state_d = S_WAIT;
				end else if (status.full) begin
					cmd.pop      = 1'b1;
					cmd.flag_ovf = 1'b1;
					state_d      = S_PUSH;
				end else begin
					cmd.push = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_WAIT: begin
				// new head entry is being read
				state_d = S_TEST;
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/swtrm_dp.sv =====
// Datapath of the rate meter: window store, running sums, scaling multipliers, result register.
module swtrm_dp #(
	parameter int unsigned FIFO_DEPTH = swtrm_pkg::FIFO_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  swtrm_pkg::dp_cmd_t                  cmd,
	output swtrm_pkg::dp_status_t               status,
	input  logic [swtrm_pkg::IN_DATA_W-1:0]     in_data,
	input  logic [swtrm_pkg::IN_USER_W-1:0]     in_user,
	input  logic                                cfg_write,
	input  logic [swtrm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [swtrm_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic [swtrm_pkg::OUT_DATA_W-1:0]    out_data,
	output logic [swtrm_pkg::OUT_USER_W-1:0]    out_user
);
	import swtrm_pkg::*;

	localparam int unsigned PTR_W  = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W  = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned SUM_W  = BITS_W + CNT_W;
	localparam int unsigned PROD_W = SUM_W + SCALE_W;
	localparam int unsigned LEXT_W = CNT_W + LOST_W;
	localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FIFO_DEPTH);

	logic [WINDOW_W-1:0] window_q;
	logic [SCALE_W-1:0]  scale_q;
	entry_t              item_q;
	entry_t              head_rd_q;
	entry_t              mem [FIFO_DEPTH];
	logic [PTR_W-1:0]    head_q;
	logic [PTR_W-1:0]    tail_q;
	logic [CNT_W-1:0]    count_q;
	logic [SUM_W-1:0]    sum_q [NUM_RATES];
	logic [CNT_W-1:0]    lost_q;
	logic                ovf_q;
	logic [PROD_W-1:0]   prod_s1 [NUM_RATES];
	logic [OUT_DATA_W-1:0] out_data_q;

	entry_t                 upd_entry;
	logic [NUM_RATES-1:0]   upd_mask;
	logic [SUM_W-1:0]       upd_bits;
	logic [RATE_W-1:0]      rate_sat [NUM_RATES];
	logic [LEXT_W-1:0]      lost_ext;
	logic [LOST_W-1:0]      lost_sat;
	logic [TIME_W:0]        limit;

	// Which sums an entry feeds
	function automatic logic [NUM_RATES-1:0] class_mask(entry_t e);
		logic [NUM_RATES-1:0] m;
		m           = '0;
		m[RC_MEDIA] = !e.rtx && !e.probe;
		m[RC_RTX]   = e.rtx && !e.probe;
		m[RC_PROBE] = !e.rtx && e.probe;
		m[RC_TOTAL] = 1'b1;
		m[RC_RECV]  = !e.lost;
		return m;
	endfunction

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			scale_q  <= SCALE_RESET;
		end else if (cfg_write) begin
			if (cfg_index == CFG_WINDOW) begin
				window_q <= cfg_data[WINDOW_W-1:0];
			end else if (cfg_index == CFG_SCALE) begin
				scale_q <= cfg_data[SCALE_W-1:0];
			end
		end
	end

	// Capture the incoming record and clear the overflow mark; set the mark on a forced eviction
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q.send_time    <= in_data[TIME_W-1:0];
			item_q.packet_bytes <= in_data[TIME_W +: BYTES_W];
			item_q.rtx          <= in_user[0];
			item_q.probe        <= in_user[1];
			item_q.lost         <= (in_data[TIME_W-1:0] != '0) && !in_user[2];
			ovf_q               <= 1'b0;
		end else if (cmd.flag_ovf) begin
			ovf_q <= 1'b1;
		end
	end

	// Window store: write at tail, read head every cycle
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[tail_q] <= item_q;
		end
		head_rd_q <= mem[head_q];
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.pop) begin
				head_q  <= (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
			if (cmd.push) begin
				tail_q  <= (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Entry that leaves or joins the window this cycle
	assign upd_entry = cmd.pop ? head_rd_q : item_q;
	assign upd_mask  = class_mask(upd_entry);
	assign upd_bits  = SUM_W'({upd_entry.packet_bytes, 3'b000});

	// Running sums and lost count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_RATES; i++) begin
				sum_q[i] <= '0;
			end
			lost_q <= '0;
		end else if (cmd.pop) begin
			for (int i = 0; i < NUM_RATES; i++) begin
				if (upd_mask[i]) begin
					sum_q[i] <= sum_q[i] - upd_bits;
				end
			end
			if (upd_entry.lost) begin
				lost_q <= lost_q - 1'b1;
			end
		end else if (cmd.push) begin
			for (int i = 0; i < NUM_RATES; i++) begin
				if (upd_mask[i]) begin
					sum_q[i] <= sum_q[i] + upd_bits;
				end
			end
			if (upd_entry.lost) begin
				lost_q <= lost_q + 1'b1;
			end
		end
	end

	// Head entry is stale when its time plus the window lies before now
	assign limit  = {1'b0, head_rd_q.send_time} + {1'b0, window_q};
	assign status.nonempty = (count_q != '0);
	assign status.full     = (count_q == FULL_CNT);
	assign status.stale    = limit < {1'b0, item_q.send_time};

	// Scale each sum to bits per second
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			for (int i = 0; i < NUM_RATES; i++) begin
				prod_s1[i] <= PROD_W'(sum_q[i]) * PROD_W'(scale_q);
			end
		end
	end

	// Saturate rates and lost count
	always_comb begin
		for (int i = 0; i < NUM_RATES; i++) begin
			rate_sat[i] = (prod_s1[i] > PROD_W'(RATE_MAX)) ? RATE_MAX
				: prod_s1[i][RATE_W-1:0];
		end
	end

	assign lost_ext = LEXT_W'(lost_q);
	assign lost_sat = (lost_ext > LEXT_W'(LOST_MAX)) ? LOST_MAX : lost_ext[LOST_W-1:0];

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= {{OUT_PAD_W{1'b0}}, lost_sat,
				rate_sat[RC_RECV], rate_sat[RC_TOTAL], rate_sat[RC_PROBE],
				rate_sat[RC_RTX], rate_sat[RC_MEDIA]};
			out_user   <= ovf_q;
		end
	end

	assign out_data = out_data_q;

endmodule

// ===== rtl/sliding_window_traffic_rate_meter.sv =====
// Top level of the sliding-window traffic rate meter.
// Each packet record beat is tested against the time window: stale entries are popped from the
// head of the window store one at a time, the oldest is evicted if the store is full, then the
// record is pushed and the five bit sums are scaled by the scale register into a result beat. The result
// is loaded once the output register is free, and the next beat is accepted only after that load,
// so beats are handled one at a time. Each stale pop waits for the new head entry to be read
// through the single registered read port of the window store. A finished result waits in an
// output register while the next beat is accepted.
// No clearing pass after reset: the fill count guards the store. Configuration writes are taken
// at any time but must only be issued while no beat is in progress.
module sliding_window_traffic_rate_meter #(
	parameter int unsigned FIFO_DEPTH = swtrm_pkg::FIFO_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// send_time[30:0], packet_bytes[46:31], zero [47]
	input  logic [swtrm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// is_retransmit[0], is_probe[1], was_received[2]
	input  logic [swtrm_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// media_rate[39:0], retransmit_rate[79:40], probe_rate[119:80], total_rate[159:120],
	// received_rate[199:160], lost_in_window[210:200], zero [215:211]
	output logic [swtrm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// fifo_overflow[0]
	output logic [swtrm_pkg::OUT_USER_W-1:0] m_axis_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [swtrm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swtrm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import swtrm_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// Registers are always writable
	assign cfg_ready = 1'b1;

	swtrm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	swtrm_dp #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

endmodule
